### rtl/power_overload_monitor_top_macros.svh
// ----------------------------------------------------------------------------
// power overload monitor assertion macros
// concurrent checks used by the pom_core module
// ----------------------------------------------------------------------------
`ifndef POWER_OVERLOAD_MONITOR_TOP_MACROS_SVH
`define POWER_OVERLOAD_MONITOR_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define POM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pom: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define POM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pom: next-cycle check failed");

`endif

### rtl/pom_pkg.sv
// ----------------------------------------------------------------------------
// pom_pkg
// types, codes and reset values of the power overload monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pom_pkg;

    // field widths
    localparam int PowW    = 24;
    localparam int LimW    = 23;
    localparam int SecW    = 8;
    localparam int LampW   = 4;
    localparam int CfgIdxW = 3;

    // event codes
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_SENSE  = 2'd0;
    localparam t_opcode OP_SECOND = 2'd1;
    localparam t_opcode OP_SHORT  = 2'd2;
    localparam t_opcode OP_LONG   = 2'd3;

    // lamp bits
    localparam logic [LampW-1:0] LAMP_GREEN  = 4'b0001;
    localparam logic [LampW-1:0] LAMP_YELLOW = 4'b0010;
    localparam logic [LampW-1:0] LAMP_BLUE   = 4'b0100;
    localparam logic [LampW-1:0] LAMP_RED    = 4'b1000;
    localparam logic [LampW-1:0] LAMP_ALL    = 4'b1111;

    // register indexes
    typedef logic [CfgIdxW-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_POWER_LIMIT    = 3'd0;
    localparam t_cfg_idx CFG_ENABLED        = 3'd1;
    localparam t_cfg_idx CFG_WARN_MARGIN    = 3'd2;
    localparam t_cfg_idx CFG_REPORT_STEP    = 3'd3;
    localparam t_cfg_idx CFG_REPORT_MAX_SEC = 3'd4;
    localparam t_cfg_idx CFG_SENSE_SEC      = 3'd5;
    localparam t_cfg_idx CFG_LONG_PRESS_SEC = 3'd6;
    localparam t_cfg_idx CFG_RESTART_SEC    = 3'd7;

    // register reset values
    localparam logic [LimW-1:0] RST_POWER_LIMIT    = 23'd3000;
    localparam logic            RST_ENABLED        = 1'b0;
    localparam logic [LimW-1:0] RST_WARN_MARGIN    = 23'd1000;
    localparam logic [LimW-1:0] RST_REPORT_STEP    = 23'd1000;
    localparam logic [SecW-1:0] RST_REPORT_MAX_SEC = 8'd60;
    localparam logic [SecW-1:0] RST_SENSE_SEC      = 8'd2;
    localparam logic [SecW-1:0] RST_LONG_PRESS_SEC = 8'd5;
    localparam logic [SecW-1:0] RST_RESTART_SEC    = 8'd5;

    typedef struct packed {
        logic [LimW-1:0] power_limit;
        logic            enabled;
        logic [LimW-1:0] warn_margin;
        logic [LimW-1:0] report_step;
        logic [SecW-1:0] report_max_seconds;
        logic [SecW-1:0] sense_period_seconds;
        logic [SecW-1:0] long_press_seconds;
        logic [SecW-1:0] restart_seconds;
    } t_cfg;

    typedef struct packed {
        t_opcode                opcode;
        logic signed [PowW-1:0] power_sample;
        logic [SecW-1:0]        press_seconds;
    } t_item;

    typedef struct packed {
        logic [LampW-1:0]       lamp_mask;
        logic                   report_now;
        logic signed [PowW-1:0] reported_power;
        logic                   blackout;
        logic [SecW-1:0]        load_count;
        logic                   sensing_on;
    } t_result;

endpackage

`default_nettype wire

### rtl/pom_if.sv
// ----------------------------------------------------------------------------
// pom_if
// valid/ready channels for event items and result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// event item channel
interface pom_item_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             opcode;
    logic signed [pom_pkg::PowW-1:0]        power_sample;
    logic [pom_pkg::SecW-1:0]               press_seconds;

    modport source (output valid, output opcode, output power_sample,
                    output press_seconds, input ready);
    modport sink   (input valid, input opcode, input power_sample,
                    input press_seconds, output ready);
endinterface

// result item channel
interface pom_result_if;
    logic                                   valid;
    logic                                   ready;
    logic [pom_pkg::LampW-1:0]              lamp_mask;
    logic                                   report_now;
    logic signed [pom_pkg::PowW-1:0]        reported_power;
    logic                                   blackout;
    logic [pom_pkg::SecW-1:0]               load_count;
    logic                                   sensing_on;

    modport source (output valid, output lamp_mask, output report_now,
                    output reported_power, output blackout, output load_count,
                    output sensing_on, input ready);
    modport sink   (input valid, input lamp_mask, input report_now,
                    input reported_power, input blackout, input load_count,
                    input sensing_on, output ready);
endinterface

`default_nettype wire

### rtl/pom_cfg_regs.sv
// ----------------------------------------------------------------------------
// pom_cfg_regs
// configuration register file with write-only access
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pom_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire pom_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [pom_pkg::LimW-1:0]     i_cfg_wdata,
    output pom_pkg::t_cfg                     o_cfg
);

    pom_pkg::t_cfg r_cfg;
    pom_pkg::t_cfg n_cfg;

    // write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pom_pkg::CFG_POWER_LIMIT:    n_cfg.power_limit = i_cfg_wdata;
                pom_pkg::CFG_ENABLED:        n_cfg.enabled     = i_cfg_wdata[0];
                pom_pkg::CFG_WARN_MARGIN:    n_cfg.warn_margin = i_cfg_wdata;
                pom_pkg::CFG_REPORT_STEP:    n_cfg.report_step = i_cfg_wdata;
                pom_pkg::CFG_REPORT_MAX_SEC:
                    n_cfg.report_max_seconds = i_cfg_wdata[pom_pkg::SecW-1:0];
                pom_pkg::CFG_SENSE_SEC:
                    n_cfg.sense_period_seconds = i_cfg_wdata[pom_pkg::SecW-1:0];
                pom_pkg::CFG_LONG_PRESS_SEC:
                    n_cfg.long_press_seconds = i_cfg_wdata[pom_pkg::SecW-1:0];
                pom_pkg::CFG_RESTART_SEC:
                    n_cfg.restart_seconds = i_cfg_wdata[pom_pkg::SecW-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_limit          <= pom_pkg::RST_POWER_LIMIT;
            r_cfg.enabled              <= pom_pkg::RST_ENABLED;
            r_cfg.warn_margin          <= pom_pkg::RST_WARN_MARGIN;
            r_cfg.report_step          <= pom_pkg::RST_REPORT_STEP;
            r_cfg.report_max_seconds   <= pom_pkg::RST_REPORT_MAX_SEC;
            r_cfg.sense_period_seconds <= pom_pkg::RST_SENSE_SEC;
            r_cfg.long_press_seconds   <= pom_pkg::RST_LONG_PRESS_SEC;
            r_cfg.restart_seconds      <= pom_pkg::RST_RESTART_SEC;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/pom_core.sv
// ----------------------------------------------------------------------------
// pom_core
// monitor state, per-event update logic and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "power_overload_monitor_top_macros.svh"

module pom_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pom_pkg::t_cfg  i_cfg,
    input  wire logic           i_take,
    input  wire pom_pkg::t_item i_item,
    input  wire logic           i_res_ready,
    output logic                o_can_take,
    output logic                o_res_valid,
    output pom_pkg::t_result    o_res
);

    // monitor state
    logic [pom_pkg::LampW-1:0]       r_lamp,      n_lamp;
    logic signed [pom_pkg::PowW-1:0] r_last,      n_last;
    logic [pom_pkg::SecW-1:0]        r_timer,     n_timer;
    logic                            r_latch,     n_latch;
    logic                            r_sensing,   n_sensing;
    logic                            r_cd_active, n_cd_active;
    logic [pom_pkg::SecW-1:0]        r_cd_value,  n_cd_value;
    logic [pom_pkg::SecW-1:0]        r_loads,     n_loads;

    // result register
    logic                            r_res_valid;
    pom_pkg::t_result                r_res, n_res;

    // sensing datapath
    logic signed [pom_pkg::PowW-1:0] s_used;
    logic signed [pom_pkg::PowW-1:0] s_band;
    logic signed [pom_pkg::PowW-1:0] s_max;
    logic [pom_pkg::LampW-1:0]       s_lamp;
    logic                            s_over;
    logic [pom_pkg::SecW:0]          s_tsum;
    logic [pom_pkg::SecW-1:0]        s_tsat;
    logic signed [pom_pkg::PowW:0]   s_diff;
    logic [pom_pkg::PowW:0]          s_abs;
    logic                            s_rep;
    logic                            s_do_sense;
    logic [pom_pkg::SecW-1:0]        s_cd_inc;

    // sample used and the classification bands
    assign s_used = i_cfg.enabled ? i_item.power_sample : '0;
    assign s_max  = $signed({1'b0, i_cfg.power_limit});
    assign s_band = $signed({1'b0, i_cfg.power_limit}) - $signed({1'b0, i_cfg.warn_margin});

    // lamp class
    always_comb begin
        s_over = 1'b0;
        if (!i_cfg.enabled) begin
            s_lamp = pom_pkg::LAMP_YELLOW;
        end else if (s_used[pom_pkg::PowW-1]) begin
            s_lamp = pom_pkg::LAMP_GREEN;
        end else if (s_used < s_band) begin
            s_lamp = pom_pkg::LAMP_BLUE;
        end else if (s_used <= s_max) begin
            s_lamp = (r_lamp & pom_pkg::LAMP_RED) ^ pom_pkg::LAMP_RED;
        end else begin
            s_lamp = pom_pkg::LAMP_RED;
            s_over = 1'b1;
        end
    end

    // saturating report timer and change detection
    assign s_tsum = {1'b0, r_timer} + {1'b0, i_cfg.sense_period_seconds};
    assign s_tsat = s_tsum[pom_pkg::SecW] ? '1 : s_tsum[pom_pkg::SecW-1:0];
    assign s_diff = {r_last[pom_pkg::PowW-1], r_last} - {s_used[pom_pkg::PowW-1], s_used};
    assign s_abs  = s_diff[pom_pkg::PowW] ? $unsigned(-s_diff) : $unsigned(s_diff);
    assign s_rep  = (s_abs >= {2'b00, i_cfg.report_step})
                 || (s_tsat >= i_cfg.report_max_seconds);

    assign s_do_sense = (i_item.opcode == pom_pkg::OP_SENSE) && r_sensing;
    assign s_cd_inc   = (r_cd_value == '1) ? r_cd_value : r_cd_value + 1'b1;

    // next state per event
    always_comb begin
        n_lamp      = r_lamp;
        n_last      = r_last;
        n_timer     = r_timer;
        n_latch     = r_latch;
        n_sensing   = r_sensing;
        n_cd_active = r_cd_active;
        n_cd_value  = r_cd_value;
        n_loads     = r_loads;
        case (i_item.opcode)
            pom_pkg::OP_SENSE: begin
                if (r_sensing) begin
                    n_lamp  = s_lamp;
                    n_latch = r_latch | s_over;
                    n_timer = s_tsat;
                    if (s_rep) begin
                        n_last  = s_used;
                        n_timer = '0;
                    end
                    // blackout drops the report history and stops sensing
                    if (r_latch | s_over) begin
                        n_last    = '0;
                        n_timer   = '0;
                        n_sensing = 1'b0;
                    end
                end
            end
            pom_pkg::OP_SECOND: begin
                if (r_cd_active) begin
                    n_cd_value = s_cd_inc;
                    if (s_cd_inc >= i_cfg.restart_seconds) begin
                        n_lamp      = pom_pkg::LAMP_ALL;
                        n_latch     = 1'b0;
                        n_sensing   = 1'b1;
                        n_cd_active = 1'b0;
                    end
                end
            end
            pom_pkg::OP_SHORT: begin
                if (i_cfg.enabled && !r_latch && (r_loads != '1)) begin
                    n_loads = r_loads + 1'b1;
                end
            end
            default: begin
                if (i_cfg.enabled && (i_item.press_seconds > i_cfg.long_press_seconds)) begin
                    n_loads     = '0;
                    n_cd_value  = '0;
                    n_cd_active = 1'b1;
                    n_sensing   = 1'b0;
                end
            end
        endcase
    end

    // result fields from the updated state
    always_comb begin
        n_res.lamp_mask      = n_lamp;
        n_res.report_now     = s_do_sense & s_rep;
        n_res.reported_power = s_do_sense ? s_used : '0;
        n_res.blackout       = n_latch;
        n_res.load_count     = n_loads;
        n_res.sensing_on     = n_sensing;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp      <= '0;
            r_last      <= '0;
            r_timer     <= '0;
            r_latch     <= 1'b0;
            r_sensing   <= 1'b1;
            r_cd_active <= 1'b0;
            r_cd_value  <= '0;
            r_loads     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_lamp      <= n_lamp;
                r_last      <= n_last;
                r_timer     <= n_timer;
                r_latch     <= n_latch;
                r_sensing   <= n_sensing;
                r_cd_active <= n_cd_active;
                r_cd_value  <= n_cd_value;
                r_loads     <= n_loads;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_res <= n_res;
        end
    end

    assign o_can_take  = !r_res_valid || i_res_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // checks
    `POM_ASSERT_IMP(a_latch_stops_sensing, i_clk, i_rst_n, r_latch, !r_sensing)
    `POM_ASSERT_IMP(a_countdown_stops_sensing, i_clk, i_rst_n, r_cd_active, !r_sensing)
    `POM_ASSERT_NXT(a_no_report_off_sense, i_clk, i_rst_n,
        i_take && (i_item.opcode != pom_pkg::OP_SENSE), !r_res.report_now)

endmodule

`default_nettype wire

### rtl/power_overload_monitor_top.sv
// ----------------------------------------------------------------------------
// power_overload_monitor_top
// event-driven overload supervisor with lamp classes, reports and restart
// ----------------------------------------------------------------------------
//  channel    dir  handshake         payload
//  i_item     in   valid/ready       opcode, power_sample, press_seconds
//  o_result   out  valid/ready       lamp_mask, report_now, reported_power,
//                                    blackout, load_count, sensing_on
//  i_cfg_*    in   write enable      register index, write data
//
//  every item produces exactly one result item, registered first in the input
//  register and then in the result register
//  one item per cycle sustained while results are taken: input register,
//  combinational update logic, result register
//  a stalled result holds the core; one more item waits in the input register
//  synchronous active-low reset restores register defaults and monitor state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module power_overload_monitor_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [pom_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [pom_pkg::LimW-1:0]   i_cfg_wdata,
    pom_item_if.sink                        i_item,
    pom_result_if.source                    o_result
);

    pom_pkg::t_cfg    w_cfg;
    pom_pkg::t_result w_res;
    logic             w_can_take;
    logic             w_res_valid;
    logic             w_take;
    logic             w_in_acc;

    // input register
    logic             r_item_valid;
    pom_pkg::t_item   r_item;

    assign w_take   = r_item_valid && w_can_take;
    assign w_in_acc = i_item.valid && i_item.ready;
    assign i_item.ready = !r_item_valid || w_take;

    // input item valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_item_valid <= 1'b1;
        end else if (w_take) begin
            r_item_valid <= 1'b0;
        end
    end

    // input item payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item.opcode        <= i_item.opcode;
            r_item.power_sample  <= i_item.power_sample;
            r_item.press_seconds <= i_item.press_seconds;
        end
    end

    pom_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    pom_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_take      (w_take),
        .i_item      (r_item),
        .i_res_ready (o_result.ready),
        .o_can_take  (w_can_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result channel
    assign o_result.valid          = w_res_valid;
    assign o_result.lamp_mask      = w_res.lamp_mask;
    assign o_result.report_now     = w_res.report_now;
    assign o_result.reported_power = w_res.reported_power;
    assign o_result.blackout       = w_res.blackout;
    assign o_result.load_count     = w_res.load_count;
    assign o_result.sensing_on     = w_res.sensing_on;

endmodule

`default_nettype wire
